// File: design/lta_pkg.sv
`default_nettype none

package lta_pkg;

  // Default table geometry
  localparam int NUM_ENTRIES_DEF = 16;
  localparam int TICKET_BITS_DEF = 16;

  // Fixed field widths on the stream ports
  localparam int IDX_BITS = 4;
  localparam int AMT_BITS = 16;
  localparam int RND_BITS = 32;
  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 24;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_DRAW = 2'd1,
    OP_XFER = 2'd2,
    OP_NONE = 2'd3
  } lta_op_e;

  // Broadcast command from the sequencer to every cell
  typedef struct packed {
    logic                load;      // write entry src with amount/runnable
    logic                apply;     // commit a transfer
    logic                walk;      // collect chain searches for the winner
    logic [IDX_BITS-1:0] src;
    logic [IDX_BITS-1:0] dst;
    logic [AMT_BITS-1:0] amount;
    logic                runnable;
  } lta_cmd_t;

endpackage

`default_nettype wire

// File: design/lottery_ticket_arbiter_unit.sv
// Channel  Dir  Handshake                 tuser  tdata
// s_axis   in   s_axis_tvalid/tready      op     entry_index, dest_index, ticket_amount,
//                                                 runnable, random_value
// m_axis   out  m_axis_tvalid/tready      -      winner_index, winner_valid, moved_tickets
//
// A load writes one entry; an unused op only returns zeros. A transfer ripples down the
// cell row to collect the amount, then commits it. A draw ripples the ticket sum down the
// cell row, runs the bit-serial modulo unit, then ripples the winner search back down the row.
// One item is in work at a time; the output register frees the input side while a
// result waits. Reset clears the table (all counts zero, nothing runnable) at once.
// A stalled output holds its result; tready stays low from the next accepted item
// until that item's result can move into the output register.
`default_nettype none

module lottery_ticket_arbiter_unit #(
  parameter int NUM_ENTRIES = lta_pkg::NUM_ENTRIES_DEF,
  parameter int TICKET_BITS = lta_pkg::TICKET_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [3:0] entry_index, [7:4] dest_index, [23:8] ticket_amount, [24] runnable,
  // [56:25] random_value, [63:57] zero
  input  wire [lta_pkg::IN_DATA_BITS-1:0]      s_axis_tdata_i,
  // [1:0] op
  input  wire [1:0]                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // [3:0] winner_index, [4] winner_valid, [20:5] moved_tickets, [23:21] zero
  output logic [lta_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata_o
);

  localparam int IdxW  = lta_pkg::IDX_BITS;
  localparam int AmtW  = lta_pkg::AMT_BITS;
  localparam int RndW  = lta_pkg::RND_BITS;
  localparam int EntW  = $clog2(NUM_ENTRIES);
  localparam int SumW  = TICKET_BITS + EntW;
  localparam int DataW = (TICKET_BITS > EntW) ? TICKET_BITS : EntW;
  localparam int CntW  = $clog2(NUM_ENTRIES + 1);
  localparam int OutW  = lta_pkg::OUT_DATA_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_DIV,
    S_WALK,
    S_XCOL,
    S_XAPP,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      cnt_q;
  lta_pkg::lta_op_e     op_in;
  logic [IdxW-1:0]      src_q, dst_q;
  logic [AmtW-1:0]      amt_q;
  logic                 run_q;
  logic [RndW-1:0]      rnd_q;
  logic [IdxW-1:0]      res_win_q;
  logic                 res_valid_q;
  logic [AmtW-1:0]      res_moved_q;
  logic                 m_valid_q;
  logic [OutW-1:0]      m_data_q;

  lta_pkg::lta_cmd_t    cmd;
  logic                 in_xfer;
  logic                 cnt_end;
  logic                 xfer_ok;
  logic                 out_load;
  logic                 div_start, div_done;
  logic [SumW-1:0]      pick;
  logic [SumW-1:0]      total;
  logic                 end_hit;
  logic [DataW-1:0]     end_data;
  logic [TICKET_BITS-1:0] moved;

  logic [SumW-1:0]      sum_w  [NUM_ENTRIES];
  logic                 hit_w  [NUM_ENTRIES];
  logic [DataW-1:0]     data_w [NUM_ENTRIES];

  assign op_in   = lta_pkg::lta_op_e'(s_axis_tuser_i);
  assign xfer_ok = (int'(s_axis_tdata_i[3:0]) < NUM_ENTRIES) &&
                   (int'(s_axis_tdata_i[7:4]) < NUM_ENTRIES);
  assign cnt_end = (cnt_q == CntW'(NUM_ENTRIES));

  // The chain only collects transfer amounts while a transfer is in flight
  assign in_xfer = (state_q == S_XCOL) || (state_q == S_XAPP);

  // Move a finished result into the output register once it is free
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_q == S_LOAD);
    cmd.apply    = (state_q == S_XAPP);
    cmd.walk     = !in_xfer;
    cmd.src      = src_q;
    cmd.dst      = dst_q;
    cmd.amount   = amt_q;
    cmd.runnable = run_q;
  end

  assign total    = sum_w[NUM_ENTRIES-1];
  assign end_hit  = hit_w[NUM_ENTRIES-1];
  assign end_data = data_w[NUM_ENTRIES-1];
  assign moved    = TICKET_BITS'(end_data);

  // Row of cells: each holds one entry and passes sum and search results onward
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    logic [SumW-1:0]  sum_in;
    logic             hit_in;
    logic [DataW-1:0] data_in;

    if (k == 0) begin : g_head
      assign sum_in  = '0;
      assign hit_in  = 1'b0;
      assign data_in = '0;
    end else begin : g_link
      assign sum_in  = sum_w[k-1];
      assign hit_in  = hit_w[k-1];
      assign data_in = data_w[k-1];
    end

    lta_cell #(
      .CELL_IDX    (k),
      .TICKET_BITS (TICKET_BITS),
      .SUM_W       (SumW),
      .DATA_W      (DataW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pick_i  (pick),
      .moved_i (moved),
      .sum_i   (sum_in),
      .sum_o   (sum_w[k]),
      .hit_i   (hit_in),
      .hit_o   (hit_w[k]),
      .data_i  (data_in),
      .data_o  (data_w[k])
    );
  end

  // Draw value = random mod total; a zero total gives no hit in the walk anyway
  assign div_start = (state_q == S_SUM) && cnt_end;

  lta_mod #(
    .DVD_W (RndW),
    .DVS_W (SumW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (total),
    .done_o     (div_done),
    .rem_o      (pick)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      amt_q       <= '0;
      run_q       <= 1'b0;
      rnd_q       <= '0;
      res_win_q   <= '0;
      res_valid_q <= 1'b0;
      res_moved_q <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // Load a finished result, or drop the output once it is taken
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= OutW'({res_moved_q, res_valid_q, res_win_q});
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (s_axis_tvalid_i) begin
            src_q       <= s_axis_tdata_i[3:0];
            dst_q       <= s_axis_tdata_i[7:4];
            amt_q       <= s_axis_tdata_i[23:8];
            run_q       <= s_axis_tdata_i[24];
            rnd_q       <= s_axis_tdata_i[56:25];
            res_win_q   <= '0;
            res_valid_q <= 1'b0;
            res_moved_q <= '0;
            unique case (op_in)
              lta_pkg::OP_LOAD: state_q <= S_LOAD;
              lta_pkg::OP_DRAW: state_q <= S_SUM;
              lta_pkg::OP_XFER: state_q <= xfer_ok ? S_XCOL : S_DONE;
              lta_pkg::OP_NONE: state_q <= S_DONE;
              default:          state_q <= S_DONE;
            endcase
          end
        end
        S_LOAD: begin
          state_q <= S_DONE;
        end
        S_SUM: begin
          // Let the running sum settle down the whole row
          cnt_q <= cnt_q + 1'b1;
          if (cnt_end) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= '0;
          if (div_done) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_end) begin
            res_win_q   <= end_data[IdxW-1:0];
            res_valid_q <= end_hit;
            state_q     <= S_DONE;
          end
        end
        S_XCOL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_end) begin
            state_q <= S_XAPP;
          end
        end
        S_XAPP: begin
          res_moved_q <= AmtW'(moved);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          // Hand the result to the output register once it is free
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("modulo unit finished outside a draw");

  a_moved_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XAPP) |-> (32'(moved) <= 32'(amt_q)))
    else $error("transfer moved more than requested");

  a_winner_needs_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && cnt_end && end_hit) |-> (total != '0))
    else $error("winner granted with zero runnable tickets");
`endif

endmodule

`default_nettype wire

// File: design/lta_cell.sv
`default_nettype none

module lta_cell #(
  parameter int CELL_IDX    = 0,
  parameter int TICKET_BITS = lta_pkg::TICKET_BITS_DEF,
  parameter int SUM_W       = 20,
  parameter int DATA_W      = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  lta_pkg::lta_cmd_t      cmd_i,
  input  wire [SUM_W-1:0]        pick_i,
  input  wire [TICKET_BITS-1:0]  moved_i,
  input  wire [SUM_W-1:0]        sum_i,
  output logic [SUM_W-1:0]       sum_o,
  input  wire                    hit_i,
  output logic                   hit_o,
  input  wire [DATA_W-1:0]       data_i,
  output logic [DATA_W-1:0]      data_o
);

  localparam int CmpW = (TICKET_BITS > lta_pkg::AMT_BITS) ? TICKET_BITS : lta_pkg::AMT_BITS;

  logic [TICKET_BITS-1:0] tickets_q, tickets_d;
  logic                   run_q, run_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   hit_q, hit_d;
  logic [DATA_W-1:0]      data_q, data_d;

  logic                   match_src, match_dst;
  logic                   want_more;
  logic [TICKET_BITS-1:0] local_moved;
  logic                   local_hit;
  logic [DATA_W-1:0]      local_data;
  logic [TICKET_BITS-1:0] base;
  logic [TICKET_BITS:0]   grown;
  logic [TICKET_BITS-1:0] dst_new;

  assign match_src = (int'(cmd_i.src) == CELL_IDX);
  assign match_dst = (int'(cmd_i.dst) == CELL_IDX);

  // Tickets this entry would give up as a transfer source
  assign want_more   = CmpW'(tickets_q) < CmpW'(cmd_i.amount);
  assign local_moved = want_more ? tickets_q : TICKET_BITS'(cmd_i.amount);

  // Running ticket sum, one entry per stage
  assign sum_d = sum_i + (run_q ? SUM_W'(tickets_q) : '0);

  // Collect chain: first hit along the row keeps its data
  assign local_hit  = cmd_i.walk ? (pick_i < sum_q) : match_src;
  assign local_data = cmd_i.walk ? DATA_W'(CELL_IDX) : DATA_W'(local_moved);
  assign hit_d      = hit_i | local_hit;
  assign data_d     = hit_i ? data_i : (local_hit ? local_data : '0);

  // Transfer commit; a same-entry transfer subtracts and adds back
  assign base    = match_src ? (tickets_q - moved_i) : tickets_q;
  assign grown   = {1'b0, base} + {1'b0, moved_i};
  assign dst_new = grown[TICKET_BITS] ? '1 : grown[TICKET_BITS-1:0];

  always_comb begin
    tickets_d = tickets_q;
    run_d     = run_q;
    if (cmd_i.load && match_src) begin
      tickets_d = TICKET_BITS'(cmd_i.amount);
      run_d     = cmd_i.runnable;
    end else if (cmd_i.apply) begin
      if (match_dst) begin
        tickets_d = dst_new;
      end else if (match_src) begin
        tickets_d = base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tickets_q <= '0;
      run_q     <= 1'b0;
      sum_q     <= '0;
      hit_q     <= 1'b0;
      data_q    <= '0;
    end else begin
      tickets_q <= tickets_d;
      run_q     <= run_d;
      sum_q     <= sum_d;
      hit_q     <= hit_d;
      data_q    <= data_d;
    end
  end

  assign sum_o  = sum_q;
  assign hit_o  = hit_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// File: design/lta_mod.sv
`default_nettype none

module lta_mod #(
  parameter int DVD_W = lta_pkg::RND_BITS,
  parameter int DVS_W = 20
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [DVD_W-1:0]  dividend_i,
  input  wire [DVS_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int StepW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q;
  logic [StepW-1:0] step_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Restoring step: bring down one dividend bit, subtract if it fits
  assign trial  = {rem_q, dvd_q[DVD_W-1]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign done_o = busy_q && (step_q == StepW'(DVD_W - 1));
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_q  <= dvd_q << 1;
      step_q <= step_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;

  localparam int NUM_ENTRIES = lta_pkg::NUM_ENTRIES_DEF;
  localparam int TICKET_BITS = lta_pkg::TICKET_BITS_DEF;
  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;

  // Longest receiver hold-off, used once to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 300;
  // Quiet cycles after the last result, a bit more than one full draw
  localparam int DRAIN_CYCLES    = 2 * NUM_ENTRIES + 60;
  // Cycles without any transfer on either side before the run is aborted
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTED    = 10;
  localparam int RANDOM_ITEMS    = 1430;
  localparam int PRESSURE_ITEMS  = 24;

  // Input item as packed on s_axis_tdata, first field in the low bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] random_value;
    logic        runnable;
    logic [15:0] ticket_amount;
    logic [3:0]  dest_index;
    logic [3:0]  entry_index;
  } arb_item_t;

  // Result as packed on m_axis_tdata
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] moved_tickets;
    logic        winner_valid;
    logic [3:0]  winner_index;
  } arb_outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  arb_item_t        s_data = '0;
  lta_pkg::lta_op_e s_user = lta_pkg::OP_NONE;
  logic             m_ready = 1'b0;
  logic             s_ready;
  logic             m_valid;
  logic [lta_pkg::OUT_DATA_BITS-1:0] m_data;

  lottery_ticket_arbiter_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the ticket table and the results still owed by the block
  logic [TICKET_BITS-1:0] shadow_tickets [NUM_ENTRIES];
  logic                   shadow_runnable[NUM_ENTRIES];
  arb_outcome_t           owed_outcomes[$];

  int  mismatch_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  rx_stall_left = 0;
  int  quiet_cycles = 0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Apply one accepted item to the shadow table and return the result it owes
  function automatic arb_outcome_t predict_outcome(lta_pkg::lta_op_e op, arb_item_t it);
    arb_outcome_t res;
    logic [31:0]  total;
    logic [31:0]  running;
    logic [31:0]  pick;
    logic [TICKET_BITS-1:0] moved;
    logic [TICKET_BITS:0]   sum;
    bit           found;
    res     = '0;
    total   = '0;
    running = '0;
    found   = 1'b0;
    case (op)
      lta_pkg::OP_LOAD: begin
        if (it.entry_index < NUM_ENTRIES) begin
          shadow_tickets[it.entry_index]  = it.ticket_amount[TICKET_BITS-1:0];
          shadow_runnable[it.entry_index] = it.runnable;
        end
      end
      lta_pkg::OP_DRAW: begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (shadow_runnable[i]) total += shadow_tickets[i];
        if (total != 0) begin
          pick = it.random_value % total;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (shadow_runnable[i] && !found) begin
              running += shadow_tickets[i];
              if (pick < running) begin
                res.winner_index = i[3:0];
                res.winner_valid = 1'b1;
                found = 1'b1;
              end
            end
          end
        end
      end
      lta_pkg::OP_XFER: begin
        if (it.entry_index < NUM_ENTRIES && it.dest_index < NUM_ENTRIES) begin
          moved = (shadow_tickets[it.entry_index] < it.ticket_amount) ?
                  shadow_tickets[it.entry_index] : it.ticket_amount;
          shadow_tickets[it.entry_index] -= moved;
          sum = shadow_tickets[it.dest_index] + moved;
          shadow_tickets[it.dest_index] = sum[TICKET_BITS] ? TICKET_MAX : sum[TICKET_BITS-1:0];
          res.moved_tickets = moved;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("%s", msg);
  endtask

  // Offer one item; hold it until the block takes it, then record its result
  task automatic send_cmd(input lta_pkg::lta_op_e op, input logic [3:0] src,
                          input logic [3:0] dst, input logic [15:0] amount,
                          input logic run, input logic [31:0] rnd);
    arb_item_t it;
    int        gap;
    it = '{pad: '0, random_value: rnd, runnable: run, ticket_amount: amount,
           dest_index: dst, entry_index: src};
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= it;
    s_user  <= op;
    do @(posedge clk_i); while (!s_ready);
    owed_outcomes.push_back(predict_outcome(op, it));
  endtask

  // Random item with a bias toward loads and draws that keep the table busy
  task automatic send_random_cmd();
    int               r;
    lta_pkg::lta_op_e op;
    logic [15:0]      amount;
    logic [31:0]      rnd;
    r = $urandom_range(0, 99);
    if (r < 35)      op = lta_pkg::OP_LOAD;
    else if (r < 70) op = lta_pkg::OP_DRAW;
    else if (r < 95) op = lta_pkg::OP_XFER;
    else             op = lta_pkg::OP_NONE;
    r = $urandom_range(0, 99);
    if (r < 45)      amount = 16'($urandom_range(0, 65535));
    else if (r < 80) amount = 16'($urandom_range(0, 255));
    else if (r < 90) amount = 16'h0000;
    else             amount = 16'hFFFF;
    r = $urandom_range(0, 9);
    if (r < 7)       rnd = $urandom();
    else if (r < 9)  rnd = $urandom_range(0, 1023);
    else             rnd = 32'hFFFF_FFFF;
    send_cmd(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), amount,
             1'($urandom_range(0, 1)), rnd);
  endtask

  // Receiver: check every transfer, then choose next cycle's tready
  always @(posedge clk_i) begin
    arb_outcome_t got;
    arb_outcome_t want;
    int           gap;
    if (rst_ni && m_valid && m_ready) begin
      got = arb_outcome_t'(m_data);
      if (owed_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result: index %0d valid %0b moved %0d",
                               got.winner_index, got.winner_valid, got.moved_tickets));
      end else begin
        want = owed_outcomes.pop_front();
        if (got.winner_index !== want.winner_index || got.winner_valid !== want.winner_valid ||
            got.moved_tickets !== want.moved_tickets)
          note_failure($sformatf({"mismatch: index exp %0d got %0d, valid exp %0b got %0b, ",
                                  "moved exp %0d got %0d"},
                                 want.winner_index, got.winner_index, want.winner_valid,
                                 got.winner_valid, want.moved_tickets, got.moved_tickets));
      end
    end
    if (hold_requests != hold_served) begin
      hold_served   = hold_requests;
      rx_stall_left = HOLD_OFF_CYCLES;
    end
    if (rx_stall_left > 0) begin
      m_ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle_on) begin
      gap = pick_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        rx_stall_left = gap - 1;
      end else begin
        m_ready <= 1'b1;
      end
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // A draw on the cleared table has nobody to grant
  task automatic test_empty_draw();
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_DRAW, 4'd15, 4'd15, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
  endtask

  // Field extremes, a waiting entry and a runnable entry with no tickets
  task automatic test_load_extremes();
    send_cmd(lta_pkg::OP_LOAD, 4'd15, 4'd0, 16'hFFFF, 1'b1, 32'd0);
    send_cmd(lta_pkg::OP_LOAD, 4'd0, 4'd15, 16'd0, 1'b1, 32'hFFFF_FFFF);
    send_cmd(lta_pkg::OP_LOAD, 4'd7, 4'd3, 16'h1234, 1'b0, 32'h5555_5555);
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(lta_pkg::OP_LOAD, 4'd1, 4'd0, 16'd1, 1'b1, 32'd0);
    // pick 0 lands on entry 1, pick 1 and above on entry 15
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'h0001_0000);
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'h0001_0001);
  endtask

  // Partial moves, saturation at the destination, same entry, zero request
  task automatic test_transfer_cases();
    send_cmd(lta_pkg::OP_LOAD, 4'd3, 4'd0, 16'hFFF0, 1'b1, 32'd0);
    send_cmd(lta_pkg::OP_XFER, 4'd15, 4'd3, 16'h0100, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_XFER, 4'd7, 4'd7, 16'hFFFF, 1'b1, 32'd0);
    send_cmd(lta_pkg::OP_XFER, 4'd3, 4'd9, 16'd0, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_XFER, 4'd1, 4'd2, 16'd5, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_XFER, 4'd3, 4'd7, 16'hFFFF, 1'b0, 32'd0);
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'hAAAA_AAAA);
  endtask

  // The spare opcode leaves the table alone and returns zeros
  task automatic test_unused_op();
    send_cmd(lta_pkg::OP_NONE, 4'd15, 4'd15, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_cmd(lta_pkg::OP_NONE, 4'd5, 4'd10, 16'h00FF, 1'b0, 32'h1234_5678);
    send_cmd(lta_pkg::OP_DRAW, 4'd0, 4'd0, 16'd0, 1'b0, 32'h0000_0003);
  endtask

  // Random traffic, idling switched per segment so bursts show up too
  task automatic test_random_traffic();
    int mode;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        mode = (n / 150) % 3;
        tx_idle_on = (mode != 1);
        rx_idle_on = (mode == 0);
      end
      send_random_cmd();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold off the receiver while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    hold_requests++;
    for (int n = 0; n < PRESSURE_ITEMS; n++) send_random_cmd();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tickets[i]  = '0;
      shadow_runnable[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_draw();
    test_load_extremes();
    test_transfer_cases();
    test_unused_op();
    test_output_backpressure();
    test_random_traffic();

    s_valid <= 1'b0;
    while (owed_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && owed_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/lta_pkg.sv
design/lta_cell.sv
design/lta_mod.sv
design/lottery_ticket_arbiter_unit.sv
tb/testbench.sv
